[hw/rtl/ilir_pkg.sv]
package ilir_pkg;

  // Request codes
  typedef enum logic [2:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_MODIFY = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Per-cell update select
  typedef enum logic [1:0] {
    SEL_HOLD  = 2'd0,
    SEL_LOAD  = 2'd1,
    SEL_LEFT  = 2'd2,
    SEL_RIGHT = 2'd3
  } cell_sel_t;

endpackage

[hw/rtl/ilir_cell.sv]
module ilir_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  ilir_pkg::cell_sel_t   sel,
  input  logic [DATA_WIDTH-1:0] load_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] q
);
  import ilir_pkg::*;

  logic [DATA_WIDTH-1:0] q_next;

  // Pick the new content: keep, new word, or a neighbor's word
  always_comb begin
    case (sel)
      SEL_HOLD:  q_next = q;
      SEL_LOAD:  q_next = load_data;
      SEL_LEFT:  q_next = left_data;
      SEL_RIGHT: q_next = right_data;
      default:   q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[hw/rtl/indexed_list_insert_remove_core.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+---------------------------------
// request   | in_valid/in_stall  | action, position, data_in
// result    | out_valid/out_stall| data_out, status, length
//
// One request per cycle while no result is held; its result appears in the cycle after acceptance.
// Every cell of the entry chain updates in the same cycle, so an insert or
// remove shifts the whole chain at once regardless of position.
// Reset (rst, synchronous) empties the list and drops any pending result.
// in_stall follows a held result: a result not taken blocks the next request.
module indexed_list_insert_remove_core #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          action,
  input  logic [3:0]          position,
  input  logic signed [31:0]  data_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  data_out,
  output logic [1:0]          status,
  output logic [4:0]          length
);
  import ilir_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;
  localparam int XW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
  localparam int LW   = (CW > 5) ? CW : 5;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
  cell_sel_t             sel    [CAPACITY];

  logic                   accept;
  logic [CMPW-1:0]        pos_w;
  logic [CMPW-1:0]        count_w;
  logic                   idx_ok;
  logic                   full;
  logic signed [XW-1:0]   din_x;
  logic [DATA_WIDTH-1:0]  store_data;
  logic [DATA_WIDTH-1:0]  rd_raw;
  logic signed [DATA_WIDTH-1:0] rd_s;
  logic signed [XW-1:0]   rd_x;
  logic [31:0]            data_out_next;
  status_t                status_next;
  logic [LW-1:0]          length_w;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_w   = CMPW'(position);
  assign count_w = CMPW'(count);
  assign idx_ok  = pos_w < count_w;
  assign full    = count == CW'(CAPACITY);

  // Input word sign-extended, then cut to the stored width
  assign din_x      = XW'(data_in);
  assign store_data = din_x[DATA_WIDTH-1:0];

  // Read port: select the addressed cell
  always_comb begin
    rd_raw = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMPW'(i) == pos_w) rd_raw = cell_q[i];
    end
  end

  assign rd_s = rd_raw;
  assign rd_x = XW'(rd_s);

  // Request decode: status, new count, cell selects, read data
  always_comb begin
    status_next   = ST_OK;
    count_next    = count;
    data_out_next = '0;
    for (int i = 0; i < CAPACITY; i++) sel[i] = SEL_HOLD;
    if (accept) begin
      case (action_t'(action))
        ACT_APPEND: begin
          if (full) begin
            status_next = ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CW'(i) == count) sel[i] = SEL_LOAD;
            end
            count_next = count + CW'(1);
          end
        end
        ACT_INSERT: begin
          if (!idx_ok) begin
            status_next = ST_BAD;
          end else if (full) begin
            status_next = ST_FULL;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMPW'(i) > pos_w) sel[i] = SEL_LEFT;
              else if (CMPW'(i) == pos_w) sel[i] = SEL_LOAD;
            end
            count_next = count + CW'(1);
          end
        end
        ACT_REMOVE: begin
          if (!idx_ok) begin
            status_next = ST_BAD;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMPW'(i) >= pos_w) sel[i] = SEL_RIGHT;
            end
            count_next = count - CW'(1);
          end
        end
        ACT_READ: begin
          if (!idx_ok) status_next = ST_BAD;
          else data_out_next = rd_x[31:0];
        end
        ACT_MODIFY: begin
          if (!idx_ok) begin
            status_next = ST_BAD;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (CMPW'(i) == pos_w) sel[i] = SEL_LOAD;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Entry chain: each cell talks to its neighbors; an end cell uses its own word on the open side
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = cell_q[g];
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    ilir_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
      .clk        (clk),
      .sel        (sel[g]),
      .load_data  (store_data),
      .left_data  (left_d),
      .right_data (right_d),
      .q          (cell_q[g])
    );
  end

  assign length_w = LW'(count_next);

  // Length counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= data_out_next;
      status   <= status_next;
      length   <= length_w[4:0];
    end
  end

endmodule

[hw/rtl/ilir_checker.sv]
module ilir_checker #(
  parameter int CAPACITY = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] data_out,
  input logic [1:0]         status,
  input logic [4:0]         length
);
  import ilir_pkg::*;

  localparam logic [4:0] CAP5 = 5'(CAPACITY);

  // Requests only wait behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("request stalled without a held result");

  // Every accepted request yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no result");

  // A held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(data_out) && $stable(status) && $stable(length)))
    else $error("held result changed");

  // A full refusal reports a full list
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (length == CAP5))
    else $error("full status with length below capacity");

  // Nonzero read data only on success
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && data_out != 32'sd0) |-> (status == ST_OK))
    else $error("read data on failed request");

endmodule

bind indexed_list_insert_remove_core ilir_checker #(.CAPACITY(CAPACITY)) u_ilir_checker (.*);

[dv/indexed_list_insert_remove_core_tb.sv]
`timescale 1ns / 1ps

module indexed_list_insert_remove_core_tb;
  import ilir_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int RANDOM_REQUESTS = 950;
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST = 3'd7;

  typedef struct {
    logic signed [31:0] data;
    status_t status;
    logic [4:0] length;
  } list_result_t;

  // Shadow copy of the list plus the queue of results still owed by the block
  class list_scoreboard;
    logic signed [31:0] cells [LIST_DEPTH];
    int count;
    list_result_t owed_q[$];
    int errors;
    int checked;
    int act_hits [8];
    int status_hits [4];

    function void note_request(logic [2:0] act, logic [3:0] pos, logic signed [31:0] value);
      list_result_t r;
      bit idx_ok;
      r.data = '0;
      r.status = ST_OK;
      idx_ok = pos < count;
      act_hits[act]++;
      case (act)
        ACT_APPEND: begin
          if (count >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            cells[count] = value;
            count++;
          end
        end
        ACT_INSERT: begin
          if (!idx_ok) r.status = ST_BAD;
          else if (count >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            for (int i = count; i > pos; i--) cells[i] = cells[i - 1];
            cells[pos] = value;
            count++;
          end
        end
        ACT_REMOVE: begin
          if (!idx_ok) r.status = ST_BAD;
          else begin
            for (int i = pos; i + 1 < count; i++) cells[i] = cells[i + 1];
            count--;
          end
        end
        ACT_READ: begin
          if (!idx_ok) r.status = ST_BAD;
          else r.data = cells[pos];
        end
        ACT_MODIFY: begin
          if (!idx_ok) r.status = ST_BAD;
          else cells[pos] = value;
        end
        default: ;  // unused codes leave the list alone
      endcase
      r.length = 5'(count);
      owed_q.push_back(r);
    endfunction

    function void check_result(logic signed [31:0] d, logic [1:0] st, logic [4:0] len);
      list_result_t e;
      if (owed_q.size() == 0) begin
        $error("result with no request outstanding: data_out=%0d status=%0d length=%0d",
               d, st, len);
        errors++;
        return;
      end
      e = owed_q.pop_front();
      checked++;
      if (!$isunknown(st)) status_hits[st]++;
      if (d !== e.data) begin
        $error("data_out mismatch: expected %0d, actual %0d", e.data, d);
        errors++;
      end
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (len !== e.length) begin
        $error("length mismatch: expected %0d, actual %0d", e.length, len);
        errors++;
      end
    endfunction

    // Requests that carried one of the unused action codes
    function int unused_hits();
      int total;
      total = 0;
      for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++) total += act_hits[a];
      return total;
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [2:0] action;
  logic [3:0] position;
  logic signed [31:0] data_in;
  logic out_valid;
  logic out_stall;
  logic signed [31:0] data_out;
  logic [1:0] status;
  logic [4:0] length;

  list_scoreboard sb = new();
  bit idle_enable;
  bit long_hold_req;
  int cycles;

  indexed_list_insert_remove_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .position(position),
    .data_in(data_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .data_out(data_out),
    .status(status),
    .length(length)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(data_out, status, length);
  end

  // Result-side back-pressure: random bursts, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
        long_hold_req = 1'b0;
      end else if (idle_enable && $urandom_range(3, 0) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(15, 1)) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offer one request and hold it until taken; called at a falling edge
  task automatic send_request(logic [2:0] act, logic [3:0] pos, logic signed [31:0] value);
    action = act;
    position = pos;
    data_in = value;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(act, pos, value);
    @(negedge clk);
    if (idle_enable && $urandom_range(5, 0) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(15, 1)) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    in_valid = 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7, 0))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid indexes, sometimes the one just past the end, sometimes anything
  function automatic logic [3:0] pick_position();
    int r;
    r = $urandom_range(9, 0);
    if (sb.count > 0 && r < 7) return 4'($urandom_range(sb.count - 1, 0));
    if (r == 7 && sb.count < LIST_DEPTH) return 4'(sb.count);
    return 4'($urandom_range(15, 0));
  endfunction

  // Phase 0 grows the list, phase 1 mixes, phase 2 shrinks it
  function automatic logic [2:0] pick_action(int phase);
    int r;
    r = $urandom_range(99, 0);
    if (r < 3) return 3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST));
    case (phase)
      0: begin
        if (r < 55) return ACT_APPEND;
        if (r < 75) return ACT_INSERT;
        if (r < 85) return ACT_READ;
        if (r < 92) return ACT_MODIFY;
        return ACT_REMOVE;
      end
      1: begin
        if (r < 22) return ACT_APPEND;
        if (r < 41) return ACT_INSERT;
        if (r < 60) return ACT_REMOVE;
        if (r < 80) return ACT_READ;
        return ACT_MODIFY;
      end
      default: begin
        if (r < 58) return ACT_REMOVE;
        if (r < 66) return ACT_APPEND;
        if (r < 72) return ACT_INSERT;
        if (r < 88) return ACT_READ;
        return ACT_MODIFY;
      end
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_APPEND;
    position = '0;
    data_in = '0;
    idle_enable = 1'b0;
    long_hold_req = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty list rejects every index, extremes, insert at length
    send_request(ACT_READ, 4'd0, 32'sd0);
    send_request(ACT_REMOVE, 4'd15, 32'sd0);
    send_request(ACT_INSERT, 4'd0, 32'sd7);
    send_request(ACT_MODIFY, 4'd0, 32'sd9);
    send_request(ACT_APPEND, 4'd0, 32'sh8000_0000);
    send_request(ACT_APPEND, 4'd15, 32'sh7fff_ffff);
    send_request(ACT_APPEND, 4'd0, 32'sd0);
    send_request(ACT_APPEND, 4'd0, -32'sd1);
    send_request(ACT_INSERT, 4'd0, 32'sh1234_5678);
    send_request(ACT_INSERT, 4'd5, 32'sd3);
    send_request(ACT_INSERT, 4'd4, 32'shdead_beef);
    send_request(ACT_READ, 4'd0, 32'sd0);
    send_request(ACT_READ, 4'd4, 32'sd0);
    send_request(ACT_READ, 4'd5, 32'sd0);
    send_request(ACT_MODIFY, 4'd2, 32'sh5555_aaaa);
    send_request(ACT_READ, 4'd2, 32'sd0);
    send_request(ACT_REMOVE, 4'd5, 32'sd0);
    send_request(ACT_REMOVE, 4'd0, 32'sd0);
    send_request(ACT_READ, 4'd0, 32'sd0);
    send_request(ACT_UNUSED_FIRST, 4'd3, 32'sd11);
    send_request(ACT_UNUSED_LAST, 4'd15, -32'sd11);
    send_request(ACT_READ, 4'd15, 32'sd0);

    // Random traffic in grow / mix / shrink phases
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      idle_enable = (n < 800) && ((n / 100) % 3 != 2);
      if (n == 300) long_hold_req = 1'b1;
      if (n == 500) wait_all_results();
      send_request(pick_action((n / 40) % 3), pick_position(), pick_value());
    end

    wait_all_results();
    repeat (4) @(negedge clk);
    $display("Requests: append %0d, insert %0d, remove %0d, read %0d, modify %0d, unused %0d",
             sb.act_hits[ACT_APPEND], sb.act_hits[ACT_INSERT], sb.act_hits[ACT_REMOVE],
             sb.act_hits[ACT_READ], sb.act_hits[ACT_MODIFY], sb.unused_hits());
    $display("Results checked %0d: ok %0d, bad index %0d, full %0d; mismatches %0d",
             sb.checked, sb.status_hits[ST_OK], sb.status_hits[ST_BAD],
             sb.status_hits[ST_FULL], sb.errors);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[indexed_list_insert_remove_core.f]
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_cell.sv
hw/rtl/indexed_list_insert_remove_core.sv
hw/rtl/ilir_checker.sv
dv/indexed_list_insert_remove_core_tb.sv
